// ===== hw/rtl/thp_pkg.sv =====
// Shared types, constants and helpers for the hydrometer gravity pipeline.
package thp_pkg;

  localparam int COEF_W    = 48;
  localparam int CFG_IDX_W = 3;
  localparam int FAC_W     = 31;
  localparam int TILT_W    = 23;
  localparam int STEPS     = 20;

  localparam logic [TILT_W-1:0]  TILT_MAX       = 23'd5898240;
  localparam logic signed [63:0] ACC_LIM        = 64'sd4611686018427387903;
  localparam logic signed [63:0] G_PRE_LIM      = 64'sd8589934592;
  localparam logic signed [COEF_W-1:0] COEF_CONST_RST = 48'sd1099511627776;

  localparam logic signed [63:0] FC_A = 64'sd281841868083799;
  localparam logic signed [63:0] FC_B = 64'sd37920906715;
  localparam logic signed [63:0] FC_C = 64'sd574356997;
  localparam logic signed [63:0] FC_D = 64'sd655333;

  localparam logic signed [63:0] PL_K0 = 64'sd43605164;
  localparam logic signed [63:0] PL_K1 = 64'sd82735923;
  localparam logic signed [63:0] PL_K2 = 64'sd50884116;
  localparam logic signed [24:0] PL_K3 = 25'sd11989156;

  // floor(2^34 / 5) + 1, exact quotient for dividends below 2^32
  localparam logic [31:0] RECIP5 = 32'hCCCCCCCD;

  localparam logic [21:0] ATAN_DEG [STEPS] = '{
    22'd2949120, 22'd1740967, 22'd919879, 22'd466945, 22'd234379,
    22'd117304,  22'd58666,   22'd29335,  22'd14668,  22'd7334,
    22'd3667,    22'd1833,    22'd917,    22'd458,    22'd229,
    22'd115,     22'd57,      22'd29,     22'd14,     22'd7
  };

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TILT4 = 3'd0,
    REG_TILT3 = 3'd1,
    REG_TILT2 = 3'd2,
    REG_TILT1 = 3'd3,
    REG_CONST = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic               sample_ok;
    logic signed [15:0] temp_c;
    logic               temp_valid;
  } in_t;

  typedef struct packed {
    logic [TILT_W-1:0]  tilt_deg;
    logic signed [31:0] gravity;
    logic signed [23:0] plato_deg;
    logic               error;
  } out_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] c4;
    logic signed [COEF_W-1:0] c3;
    logic signed [COEF_W-1:0] c2;
    logic signed [COEF_W-1:0] c1;
    logic signed [COEF_W-1:0] c0;
  } coef_t;

  typedef struct packed {
    logic                     err;
    logic                     tv;
    logic signed [FAC_W-1:0]  fac;
  } side_t;

  // shift right by s, rounding half away from zero
  function automatic logic signed [63:0] rnd_shr(input logic signed [63:0] v,
                                                 input int unsigned s);
    logic signed [63:0] half;
    half = 64'sd1 <<< (s - 1);
    return (v + half - (v < 0 ? 64'sd1 : 64'sd0)) >>> s;
  endfunction

endpackage

// ===== hw/rtl/thp_tfac.sv =====
// Temperature correction factor pipeline: Fahrenheit conversion and cubic, Q28 out.
module thp_tfac (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  thp_pkg::in_t                      in_item,
  output logic                              out_valid,
  output thp_pkg::in_t                      out_item,
  output logic signed [thp_pkg::FAC_W-1:0]  out_fac
);

  localparam int LAT   = 10;
  localparam int T_W   = 27;
  localparam int P_W   = 52;
  localparam int M_W   = 39;
  localparam int SPLIT = 20;
  localparam logic signed [63:0] KADD [3] = '{thp_pkg::FC_C, -thp_pkg::FC_B, thp_pkg::FC_A};

  logic [LAT-1:0] vld;
  thp_pkg::in_t   itm [LAT];

  logic signed [27:0] n_c;
  logic [27:0]        a1;
  logic               neg1, neg2;
  logic [59:0]        p2r;
  logic signed [T_W-1:0] t3;

  logic signed [T_W-1:0]            ta   [3];
  logic signed [T_W-1:0]            tb   [3];
  logic signed [M_W-SPLIT+T_W-1:0]  mh   [3];
  logic signed [SPLIT+T_W:0]        ml   [3];
  logic signed [P_W-1:0]            pst  [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LAT-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    itm[0] <= in_item;
    for (int k = 1; k < LAT; k++) begin
      itm[k] <= itm[k-1];
    end
  end

  assign n_c = (28'(in_item.temp_c) * 28'sd9 + 28'sd40960) <<< 8;

  always_ff @(posedge clk) begin
    neg1 <= n_c[27];
    a1   <= (n_c[27] ? $unsigned(-n_c) : $unsigned(n_c)) + 28'd2;
    neg2 <= neg1;
    p2r  <= a1 * thp_pkg::RECIP5;
    t3   <= neg2 ? -$signed({1'b0, p2r[59:34]}) : $signed({1'b0, p2r[59:34]});
  end

  for (genvar j = 0; j < 3; j++) begin : g_step
    logic signed [M_W-1:0] pm;
    logic signed [T_W-1:0] ti;
    logic signed [63:0]    sum;

    if (j == 0) begin : g_first
      assign pm = M_W'(-thp_pkg::FC_D);
      assign ti = t3;
    end else begin : g_next
      assign pm = pst[j-1][M_W-1:0];
      assign ti = tb[j-1];
    end

    assign sum = (64'(mh[j]) <<< SPLIT) + 64'(ml[j]);

    always_ff @(posedge clk) begin
      mh[j]  <= $signed(pm[M_W-1:SPLIT]) * ti;
      ml[j]  <= $signed({1'b0, pm[SPLIT-1:0]}) * ti;
      ta[j]  <= ti;
      tb[j]  <= ta[j];
      pst[j] <= P_W'(thp_pkg::rnd_shr(sum, 16) + KADD[j]);
    end
  end

  always_ff @(posedge clk) begin
    out_fac <= thp_pkg::FAC_W'(thp_pkg::rnd_shr(64'(pst[2]), 20));
  end

  assign out_valid = vld[LAT-1];
  assign out_item  = itm[LAT-1];

endmodule

// ===== hw/rtl/thp_isqrt.sv =====
// Pipelined integer square root, one result bit per stage.
module thp_isqrt (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic [31:0]          in_rad,
  input  logic [16:0]          in_ymag,
  input  thp_pkg::side_t       in_side,
  output logic                 out_valid,
  output logic [31:0]          out_root,
  output logic [16:0]          out_ymag,
  output thp_pkg::side_t       out_side
);

  localparam int LAT = 32;

  logic [LAT-1:0]  vld;
  logic [63:0]     rem  [LAT];
  logic [63:0]     root [LAT];
  logic [16:0]     ym   [LAT];
  thp_pkg::side_t  sd   [LAT];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LAT-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    ym[0] <= in_ymag;
    sd[0] <= in_side;
    for (int k = 1; k < LAT; k++) begin
      ym[k] <= ym[k-1];
      sd[k] <= sd[k-1];
    end
  end

  for (genvar k = 0; k < LAT; k++) begin : g_stage
    localparam logic [63:0] BIT = 64'd1 << (2 * (LAT - 1 - k));
    logic [63:0] rem_i, root_i, trial;

    if (k == 0) begin : g_first
      assign rem_i  = {in_rad, 32'd0};
      assign root_i = '0;
    end else begin : g_next
      assign rem_i  = rem[k-1];
      assign root_i = root[k-1];
    end

    assign trial = root_i + BIT;

    always_ff @(posedge clk) begin
      if (rem_i >= trial) begin
        rem[k]  <= rem_i - trial;
        root[k] <= (root_i >> 1) + BIT;
      end else begin
        rem[k]  <= rem_i;
        root[k] <= root_i >> 1;
      end
    end
  end

  assign out_valid = vld[LAT-1];
  assign out_root  = root[LAT-1][31:0];
  assign out_ymag  = ym[LAT-1];
  assign out_side  = sd[LAT-1];

endmodule

// ===== hw/rtl/thp_cordic.sv =====
// Vectoring CORDIC, one iteration per stage, angle in Q16 degrees, then clamp.
module thp_cordic (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic signed [35:0]          in_x,
  input  logic signed [35:0]          in_y,
  input  thp_pkg::side_t              in_side,
  output logic                        out_valid,
  output logic [thp_pkg::TILT_W-1:0]  out_tilt,
  output thp_pkg::side_t              out_side
);

  localparam int N   = thp_pkg::STEPS;
  localparam int LAT = N + 1;

  logic [LAT-1:0]      vld;
  thp_pkg::side_t      sd [LAT];
  logic signed [35:0]  cx [N];
  logic signed [35:0]  cy [N];
  logic signed [23:0]  an [N];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LAT-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    sd[0] <= in_side;
    for (int k = 1; k < LAT; k++) begin
      sd[k] <= sd[k-1];
    end
  end

  for (genvar k = 0; k < N; k++) begin : g_iter
    localparam logic signed [23:0] ATN = $signed({2'b00, thp_pkg::ATAN_DEG[k]});
    logic signed [35:0] xi, yi, dx, dy;
    logic signed [23:0] ai;

    if (k == 0) begin : g_first
      assign xi = in_x;
      assign yi = in_y;
      assign ai = '0;
    end else begin : g_next
      assign xi = cx[k-1];
      assign yi = cy[k-1];
      assign ai = an[k-1];
    end

    assign dx = yi >>> k;
    assign dy = xi >>> k;

    always_ff @(posedge clk) begin
      priority if (yi > 0) begin
        cx[k] <= xi + dx;
        cy[k] <= yi - dy;
        an[k] <= ai + ATN;
      end else if (yi < 0) begin
        cx[k] <= xi - dx;
        cy[k] <= yi + dy;
        an[k] <= ai - ATN;
      end else begin
        cx[k] <= xi;
        cy[k] <= yi;
        an[k] <= ai;
      end
    end
  end

  always_ff @(posedge clk) begin
    priority if (an[N-1] < 0) begin
      out_tilt <= '0;
    end else if (an[N-1] > $signed({1'b0, thp_pkg::TILT_MAX})) begin
      out_tilt <= thp_pkg::TILT_MAX;
    end else begin
      out_tilt <= an[N-1][thp_pkg::TILT_W-1:0];
    end
  end

  assign out_valid = vld[LAT-1];
  assign out_side  = sd[LAT-1];

endmodule

// ===== hw/rtl/thp_grav.sv =====
// Gravity polynomial in Q40, Horner form, three stages per term, then Q28 round.
module thp_grav (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic [thp_pkg::TILT_W-1:0]  in_tilt,
  input  thp_pkg::side_t              in_side,
  input  thp_pkg::coef_t              coef,
  output logic                        out_valid,
  output logic signed [34:0]          out_g,
  output logic [thp_pkg::TILT_W-1:0]  out_tilt,
  output thp_pkg::side_t              out_side
);

  localparam int LAT = 13;
  localparam logic [52:0] HSAT  = 53'd1 << 46;
  localparam logic [63:0] LIM_U = thp_pkg::ACC_LIM;

  logic [LAT-1:0]                vld;
  logic [thp_pkg::TILT_W-1:0]    tl [LAT];
  thp_pkg::side_t                sd [LAT];

  logic signed [thp_pkg::COEF_W-1:0] cadd [4];
  logic [61:0]         am  [4];
  logic                asg [4];
  logic [52:0]         bh  [4];
  logic [54:0]         bl  [4];
  logic                bsg [4];
  logic signed [63:0]  acc [4];
  logic signed [63:0]  gr;

  always_comb begin
    cadd[0] = coef.c3;
    cadd[1] = coef.c2;
    cadd[2] = coef.c1;
    cadd[3] = coef.c0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LAT-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    tl[0] <= in_tilt;
    sd[0] <= in_side;
    for (int k = 1; k < LAT; k++) begin
      tl[k] <= tl[k-1];
      sd[k] <= sd[k-1];
    end
  end

  for (genvar j = 0; j < 4; j++) begin : g_term
    logic signed [63:0] acc_i, sv, sum;
    logic [63:0]        r_raw, r_mag;

    if (j == 0) begin : g_first
      assign acc_i = 64'(coef.c4);
    end else begin : g_next
      assign acc_i = acc[j-1];
    end

    assign r_raw = (64'(bh[j]) << 16) + ((64'(bl[j]) + 64'd32768) >> 16);
    assign r_mag = (bh[j] >= HSAT) ? LIM_U : ((r_raw > LIM_U) ? LIM_U : r_raw);
    assign sv    = bsg[j] ? -$signed(r_mag) : $signed(r_mag);
    assign sum   = sv + 64'(cadd[j]);

    always_ff @(posedge clk) begin
      asg[j] <= acc_i < 0;
      am[j]  <= acc_i < 0 ? 62'(-acc_i) : acc_i[61:0];
      bsg[j] <= asg[j];
      bh[j]  <= am[j][61:32] * tl[3*j];
      bl[j]  <= am[j][31:0] * tl[3*j];
      priority if (sum > thp_pkg::ACC_LIM) begin
        acc[j] <= thp_pkg::ACC_LIM;
      end else if (sum < -thp_pkg::ACC_LIM) begin
        acc[j] <= -thp_pkg::ACC_LIM;
      end else begin
        acc[j] <= sum;
      end
    end
  end

  assign gr = thp_pkg::rnd_shr(acc[3], 12);

  always_ff @(posedge clk) begin
    priority if (gr > thp_pkg::G_PRE_LIM) begin
      out_g <= 35'(thp_pkg::G_PRE_LIM);
    end else if (gr < -thp_pkg::G_PRE_LIM) begin
      out_g <= 35'(-thp_pkg::G_PRE_LIM);
    end else begin
      out_g <= 35'(gr);
    end
  end

  assign out_valid = vld[LAT-1];
  assign out_tilt  = tl[LAT-1];
  assign out_side  = sd[LAT-1];

endmodule

// ===== hw/rtl/thp_out.sv =====
// Temperature correction, 32-bit saturation, Plato cubic and result register.
module thp_out (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic signed [34:0]          in_g,
  input  logic [thp_pkg::TILT_W-1:0]  in_tilt,
  input  thp_pkg::side_t              in_side,
  output logic                        out_valid,
  output thp_pkg::out_t               out_res
);

  localparam int LAT = 10;
  localparam logic signed [63:0] GS_MAX = 64'sd2147483647;
  localparam logic signed [63:0] GS_MIN = -64'sd2147483648;
  localparam logic signed [34:0] PL_MAX = 35'sd8388607;
  localparam logic signed [34:0] PL_MIN = -35'sd8388608;

  logic [LAT-1:0]               vld;
  logic [thp_pkg::TILT_W-1:0]   tl [LAT];
  logic                         er [LAT];
  logic signed [31:0]           gsp [7];

  logic signed [49:0]  h1;
  logic signed [47:0]  l1;
  logic signed [34:0]  g1;
  logic                tv1;
  logic signed [63:0]  sum2;
  logic signed [39:0]  g2;
  logic signed [56:0]  pr4;
  logic signed [28:0]  q5;
  logic signed [60:0]  pr6;
  logic signed [31:0]  q7;
  logic signed [63:0]  pr8;
  logic signed [34:0]  q9;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LAT-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    tl[0] <= in_tilt;
    er[0] <= in_side.err;
    for (int k = 1; k < LAT; k++) begin
      tl[k] <= tl[k-1];
      er[k] <= er[k-1];
    end
  end

  assign sum2 = (64'(h1) <<< 16) + 64'(l1);

  always_ff @(posedge clk) begin
    h1  <= $signed(in_g[34:16]) * in_side.fac;
    l1  <= $signed({1'b0, in_g[15:0]}) * in_side.fac;
    g1  <= in_g;
    tv1 <= in_side.tv;
    g2  <= tv1 ? 40'(thp_pkg::rnd_shr(sum2, 28)) : 40'(g1);
    priority if (64'(g2) > GS_MAX) begin
      gsp[0] <= 32'(GS_MAX);
    end else if (64'(g2) < GS_MIN) begin
      gsp[0] <= 32'(GS_MIN);
    end else begin
      gsp[0] <= 32'(g2);
    end
    for (int k = 1; k < 7; k++) begin
      gsp[k] <= gsp[k-1];
    end
    pr4 <= thp_pkg::PL_K3 * gsp[0];
    q5  <= 29'(thp_pkg::rnd_shr(64'(pr4), 28) - thp_pkg::PL_K2);
    pr6 <= q5 * gsp[2];
    q7  <= 32'(thp_pkg::rnd_shr(64'(pr6), 28) + thp_pkg::PL_K1);
    pr8 <= q7 * gsp[4];
    q9  <= 35'(thp_pkg::rnd_shr(pr8, 28) - thp_pkg::PL_K0);
  end

  always_ff @(posedge clk) begin
    if (er[LAT-2]) begin
      out_res <= '{tilt_deg: '0, gravity: '0, plato_deg: '0, error: 1'b1};
    end else begin
      out_res.tilt_deg <= tl[LAT-2];
      out_res.gravity  <= gsp[6];
      out_res.error    <= 1'b0;
      priority if (q9 > PL_MAX) begin
        out_res.plato_deg <= 24'(PL_MAX);
      end else if (q9 < PL_MIN) begin
        out_res.plato_deg <= 24'(PL_MIN);
      end else begin
        out_res.plato_deg <= 24'(q9);
      end
    end
  end

  assign out_valid = vld[LAT-1];

endmodule

// ===== hw/rtl/tilt_hydrometer_plato.sv =====
// Top level: tilt, specific gravity and degrees Plato from an accelerometer sample.
// One sample per cycle; busy is high only in reset and the cycle after it.
// done follows start via input register, tfac, squarer, isqrt, cordic, grav and out.
// Most of the depth comes from the 32-stage square root and the 20-stage CORDIC chain.
// Synchronous reset clears all valid bits and loads the default coefficients.
module tilt_hydrometer_plato (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  thp_pkg::in_t                        sample,
  output logic                                done,
  output thp_pkg::out_t                       result,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [thp_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [thp_pkg::COEF_W-1:0]          cfg_data
);

  logic                rst_d;
  thp_pkg::coef_t      coef;
  logic                in_vld;
  thp_pkg::in_t        in_item;

  logic                tf_vld;
  thp_pkg::in_t        tf_item;
  logic signed [thp_pkg::FAC_W-1:0] tf_fac;

  logic signed [31:0]  xsq, zsq;
  logic signed [16:0]  yext;
  logic                sq_vld;
  logic [31:0]         sq_rad;
  logic [16:0]         sq_ym;
  thp_pkg::side_t      sq_side;

  logic                rt_vld;
  logic [31:0]         rt_root;
  logic [16:0]         rt_ym;
  thp_pkg::side_t      rt_side;

  logic                co_vld;
  logic [thp_pkg::TILT_W-1:0] co_tilt;
  thp_pkg::side_t      co_side;

  logic                gv_vld;
  logic signed [34:0]  gv_g;
  logic [thp_pkg::TILT_W-1:0] gv_tilt;
  thp_pkg::side_t      gv_side;

  always_ff @(posedge clk) begin
    rst_d <= rst;
  end

  assign busy      = rst | rst_d;
  assign cfg_ready = ~busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef <= '{c4: '0, c3: '0, c2: '0, c1: '0, c0: thp_pkg::COEF_CONST_RST};
    end else if (cfg_valid && cfg_ready) begin
      unique case (thp_pkg::reg_idx_e'(cfg_index))
        thp_pkg::REG_TILT4: coef.c4 <= cfg_data;
        thp_pkg::REG_TILT3: coef.c3 <= cfg_data;
        thp_pkg::REG_TILT2: coef.c2 <= cfg_data;
        thp_pkg::REG_TILT1: coef.c1 <= cfg_data;
        thp_pkg::REG_CONST: coef.c0 <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else begin
      in_vld <= start & ~busy;
    end
  end

  always_ff @(posedge clk) begin
    in_item <= sample;
  end

  thp_tfac u_tfac (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_vld),
    .in_item   (in_item),
    .out_valid (tf_vld),
    .out_item  (tf_item),
    .out_fac   (tf_fac)
  );

  assign xsq  = tf_item.accel_x * tf_item.accel_x;
  assign zsq  = tf_item.accel_z * tf_item.accel_z;
  assign yext = 17'(tf_item.accel_y);

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_vld <= 1'b0;
    end else begin
      sq_vld <= tf_vld;
    end
  end

  always_ff @(posedge clk) begin
    sq_rad       <= $unsigned(xsq) + $unsigned(zsq);
    sq_ym        <= yext[16] ? $unsigned(-yext) : $unsigned(yext);
    sq_side.err  <= ~tf_item.sample_ok |
                    ((tf_item.accel_x == '0) && (tf_item.accel_y == '0) &&
                     (tf_item.accel_z == '0));
    sq_side.tv   <= tf_item.temp_valid;
    sq_side.fac  <= tf_fac;
  end

  thp_isqrt u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sq_vld),
    .in_rad    (sq_rad),
    .in_ymag   (sq_ym),
    .in_side   (sq_side),
    .out_valid (rt_vld),
    .out_root  (rt_root),
    .out_ymag  (rt_ym),
    .out_side  (rt_side)
  );

  thp_cordic u_cordic (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (rt_vld),
    .in_x      ($signed({3'b000, rt_ym, 16'd0})),
    .in_y      ($signed({4'b0000, rt_root})),
    .in_side   (rt_side),
    .out_valid (co_vld),
    .out_tilt  (co_tilt),
    .out_side  (co_side)
  );

  thp_grav u_grav (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (co_vld),
    .in_tilt   (co_tilt),
    .in_side   (co_side),
    .coef      (coef),
    .out_valid (gv_vld),
    .out_g     (gv_g),
    .out_tilt  (gv_tilt),
    .out_side  (gv_side)
  );

  thp_out u_out (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (gv_vld),
    .in_g      (gv_g),
    .in_tilt   (gv_tilt),
    .in_side   (gv_side),
    .out_valid (done),
    .out_res   (result)
  );

endmodule

// ===== hw/rtl/thp_chk.sv =====
// Port-level checks for the hydrometer pipeline, bound to the top level.
module thp_chk (
  input logic           clk,
  input logic           rst,
  input logic           start,
  input logic           busy,
  input logic           done,
  input thp_pkg::out_t  result
);

  localparam int LAT = 88;

  a_lat_fwd : assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LAT done)
    else $error("accepted sample produced no result");

  a_lat_bwd : assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LAT))
    else $error("result without a matching transfer");

  a_err_zero : assert property (@(posedge clk) disable iff (rst)
    (done && result.error) |->
      (result.tilt_deg == '0 && result.gravity == '0 && result.plato_deg == '0))
    else $error("error result carries nonzero fields");

  a_tilt_rng : assert property (@(posedge clk) disable iff (rst)
    (done && !result.error) |-> (result.tilt_deg <= 23'd5898240))
    else $error("tilt above 90 degrees");

endmodule

bind tilt_hydrometer_plato thp_chk u_thp_chk (.*);
